/* sv/tksd_pkg.sv */
// tksd_pkg: key codes and byte constants for the terminal key sequence decoder
`default_nettype none
package tksd_pkg;

    localparam int unsigned KeyW  = 5;
    localparam int unsigned ByteW = 8;

    // key codes
    localparam logic [KeyW-1:0] KEY_CHAR  = 5'd0;
    localparam logic [KeyW-1:0] KEY_EOT   = 5'd1;
    localparam logic [KeyW-1:0] KEY_ESC   = 5'd2;
    localparam logic [KeyW-1:0] KEY_ENTER = 5'd3;
    localparam logic [KeyW-1:0] KEY_TAB   = 5'd4;
    localparam logic [KeyW-1:0] KEY_BKSP  = 5'd5;
    localparam logic [KeyW-1:0] KEY_UP    = 5'd6;
    localparam logic [KeyW-1:0] KEY_HOME  = 5'd10;
    localparam logic [KeyW-1:0] KEY_END   = 5'd11;
    localparam logic [KeyW-1:0] KEY_INS   = 5'd12;
    localparam logic [KeyW-1:0] KEY_DEL   = 5'd13;
    localparam logic [KeyW-1:0] KEY_PGUP  = 5'd14;
    localparam logic [KeyW-1:0] KEY_PGDN  = 5'd15;
    localparam logic [KeyW-1:0] KEY_F1    = 5'd16;
    localparam logic [KeyW-1:0] KEY_F5    = 5'd20;
    localparam logic [KeyW-1:0] KEY_F6    = 5'd21;
    localparam logic [KeyW-1:0] KEY_F7    = 5'd22;
    localparam logic [KeyW-1:0] KEY_F8    = 5'd23;
    localparam logic [KeyW-1:0] KEY_F9    = 5'd24;
    localparam logic [KeyW-1:0] KEY_F10   = 5'd25;
    localparam logic [KeyW-1:0] KEY_F11   = 5'd26;
    localparam logic [KeyW-1:0] KEY_F12   = 5'd27;
    localparam logic [KeyW-1:0] KEY_UNK   = 5'd28;

    // received byte values
    localparam logic [ByteW-1:0] CH_CTRL_B = 8'h02;
    localparam logic [ByteW-1:0] CH_EOT    = 8'h04;
    localparam logic [ByteW-1:0] CH_CTRL_E = 8'h05;
    localparam logic [ByteW-1:0] CH_BS     = 8'h08;
    localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_ESC    = 8'h1B;
    localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ByteW-1:0] CH_0      = 8'h30;
    localparam logic [ByteW-1:0] CH_1      = 8'h31;
    localparam logic [ByteW-1:0] CH_2      = 8'h32;
    localparam logic [ByteW-1:0] CH_3      = 8'h33;
    localparam logic [ByteW-1:0] CH_4      = 8'h34;
    localparam logic [ByteW-1:0] CH_5      = 8'h35;
    localparam logic [ByteW-1:0] CH_6      = 8'h36;
    localparam logic [ByteW-1:0] CH_7      = 8'h37;
    localparam logic [ByteW-1:0] CH_8      = 8'h38;
    localparam logic [ByteW-1:0] CH_9      = 8'h39;
    localparam logic [ByteW-1:0] CH_A      = 8'h41;
    localparam logic [ByteW-1:0] CH_D      = 8'h44;
    localparam logic [ByteW-1:0] CH_F      = 8'h46;
    localparam logic [ByteW-1:0] CH_H      = 8'h48;
    localparam logic [ByteW-1:0] CH_O      = 8'h4F;
    localparam logic [ByteW-1:0] CH_P      = 8'h50;
    localparam logic [ByteW-1:0] CH_S      = 8'h53;
    localparam logic [ByteW-1:0] CH_LBRACK = 8'h5B;
    localparam logic [ByteW-1:0] CH_TILDE  = 8'h7E;
    localparam logic [ByteW-1:0] CH_DEL    = 8'h7F;

endpackage
`default_nettype wire

/* sv/terminal_key_sequence_decoder.sv */
// terminal_key_sequence_decoder: turns received terminal bytes into key codes
// each item is held in the input reg, then in the result reg, before its result is valid
// throughput: one item per cycle while o_stall is low; the parse phase is updated as each item is decoded
// an item that completes no key (ESC, CSI prefix bytes) produces no result
// reset: synchronous active low; clears both pipeline valids, phase to idle,
// pending key to zero
`default_nettype none
module terminal_key_sequence_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [4:0]      o_key_code,
    output logic [7:0]      o_char_value
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_CSI   = 3'd2,
        PH_CSI1  = 3'd3,
        PH_CSI2  = 3'd4,
        PH_TILDE = 3'd5,
        PH_SS3   = 3'd6
    } t_phase;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_phase      r_phase, n_phase;
    logic [4:0]  r_pending, n_pending;
    logic        r_out_valid;
    logic [4:0]  r_out_key;
    logic [7:0]  r_out_char;

    logic        emit;
    logic [4:0]  key;
    logic [7:0]  chr;
    logic        out_free;
    logic        advance;

    // handshake: the decode stage moves when the result register can take a value
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // decode of the registered byte against the current phase
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        emit      = 1'b0;
        key       = tksd_pkg::KEY_UNK;
        chr       = 8'd0;
        case (r_phase)
            PH_ESC: begin
                if (r_in_byte == tksd_pkg::CH_LBRACK) begin
                    n_phase = PH_CSI;
                end else if (r_in_byte == tksd_pkg::CH_O) begin
                    n_phase = PH_SS3;
                end else begin
                    emit = 1'b1;
                    key  = tksd_pkg::KEY_ESC;
                end
            end
            PH_CSI: begin
                case (r_in_byte) inside
                    tksd_pkg::CH_1: n_phase = PH_CSI1;
                    tksd_pkg::CH_2: n_phase = PH_CSI2;
                    tksd_pkg::CH_3: begin
                        n_phase = PH_TILDE; n_pending = tksd_pkg::KEY_DEL;
                    end
                    tksd_pkg::CH_5: begin
                        n_phase = PH_TILDE; n_pending = tksd_pkg::KEY_PGUP;
                    end
                    tksd_pkg::CH_6: begin
                        n_phase = PH_TILDE; n_pending = tksd_pkg::KEY_PGDN;
                    end
                    [tksd_pkg::CH_A:tksd_pkg::CH_D]: begin
                        emit = 1'b1;
                        key  = tksd_pkg::KEY_UP + 5'(r_in_byte[2:0] - 3'd1);
                    end
                    tksd_pkg::CH_CTRL_E, tksd_pkg::CH_F: begin
                        emit = 1'b1; key = tksd_pkg::KEY_END;
                    end
                    tksd_pkg::CH_CTRL_B, tksd_pkg::CH_H: begin
                        emit = 1'b1; key = tksd_pkg::KEY_HOME;
                    end
                    default: emit = 1'b1;
                endcase
            end
            PH_CSI1: begin
                n_phase = PH_TILDE;
                case (r_in_byte)
                    tksd_pkg::CH_5: n_pending = tksd_pkg::KEY_F5;
                    tksd_pkg::CH_7: n_pending = tksd_pkg::KEY_F6;
                    tksd_pkg::CH_8: n_pending = tksd_pkg::KEY_F7;
                    tksd_pkg::CH_9: n_pending = tksd_pkg::KEY_F8;
                    default: begin
                        n_phase = PH_IDLE; emit = 1'b1;
                    end
                endcase
            end
            PH_CSI2: begin
                n_phase = PH_TILDE;
                case (r_in_byte)
                    tksd_pkg::CH_0: n_pending = tksd_pkg::KEY_F9;
                    tksd_pkg::CH_1: n_pending = tksd_pkg::KEY_F10;
                    tksd_pkg::CH_3: n_pending = tksd_pkg::KEY_F11;
                    tksd_pkg::CH_4: n_pending = tksd_pkg::KEY_F12;
                    tksd_pkg::CH_TILDE: begin
                        n_phase = PH_IDLE; emit = 1'b1; key = tksd_pkg::KEY_INS;
                    end
                    default: begin
                        n_phase = PH_IDLE; emit = 1'b1;
                    end
                endcase
            end
            PH_TILDE: begin
                emit = 1'b1;
                if (r_in_byte == tksd_pkg::CH_TILDE) begin
                    key = r_pending;
                end
            end
            PH_SS3: begin
                emit = 1'b1;
                case (r_in_byte) inside
                    tksd_pkg::CH_CTRL_E, tksd_pkg::CH_F: key = tksd_pkg::KEY_END;
                    tksd_pkg::CH_CTRL_B, tksd_pkg::CH_H: key = tksd_pkg::KEY_HOME;
                    [tksd_pkg::CH_P:tksd_pkg::CH_S]:
                        key = tksd_pkg::KEY_F1 + 5'(r_in_byte[1:0]);
                    default: key = tksd_pkg::KEY_UNK;
                endcase
            end
            default: begin
                // idle, and the unused phase code
                emit = 1'b1;
                case (r_in_byte) inside
                    [tksd_pkg::CH_SPACE:tksd_pkg::CH_TILDE]: begin
                        key = tksd_pkg::KEY_CHAR; chr = r_in_byte;
                    end
                    tksd_pkg::CH_EOT: key = tksd_pkg::KEY_EOT;
                    tksd_pkg::CH_ESC: begin
                        emit = 1'b0; n_phase = PH_ESC;
                    end
                    tksd_pkg::CH_CR, tksd_pkg::CH_LF: key = tksd_pkg::KEY_ENTER;
                    tksd_pkg::CH_TAB: key = tksd_pkg::KEY_TAB;
                    tksd_pkg::CH_DEL, tksd_pkg::CH_BS: key = tksd_pkg::KEY_BKSP;
                    default: key = tksd_pkg::KEY_UNK;
                endcase
            end
        endcase
        // every emitted key closes the sequence
        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    // input register, phase state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pending   <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
                if (i_valid) begin
                    r_in_byte <= i_rx_byte;
                end
            end
            if (advance) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
            end
            if (out_free) begin
                r_out_valid <= advance && emit;
                if (advance && emit) begin
                    r_out_key  <= key;
                    r_out_char <= chr;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_code   = r_out_key;
    assign o_char_value = r_out_char;

endmodule
`default_nettype wire
